// File: hdl/mvm_pkg.sv
package mvm_pkg;

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;

  localparam int OPCODE_W  = 2;
  localparam int SEL_W     = 6;
  localparam int VALUE_W   = 16;
  localparam int ROW_IDX_W = 6;
  localparam int PROD_W    = 2 * VALUE_W;
  localparam int SUM_W     = 40;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam int ROW_CW = $clog2(MAX_ROWS + 1);
  localparam int COL_CW = $clog2(MAX_COLS + 1);
  localparam int WDEPTH = MAX_ROWS * MAX_COLS;
  localparam int WA_W   = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int VA_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD_WEIGHT = 2'd0,
    OP_LOAD_ELEM   = 2'd1,
    OP_RUN         = 2'd2
  } opcode_t;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b1;

  // control riding alongside one product slot
  typedef struct packed {
    logic                 valid;
    logic                 first;
    logic                 last_col;
    logic                 zero;
    logic                 last_row;
    logic [ROW_IDX_W-1:0] row;
  } mac_ctl_t;

endpackage

// File: hdl/mvm_ram.sv
module mvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/mvm_mac.sv
module mvm_mac (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  mvm_pkg::mac_ctl_t                      ctl_in,
  input  logic signed [mvm_pkg::VALUE_W-1:0]     weight,
  input  logic signed [mvm_pkg::VALUE_W-1:0]     elem,
  output logic                                   busy,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [mvm_pkg::ROW_IDX_W-1:0]          out_row_index,
  output logic signed [mvm_pkg::SUM_W-1:0]       out_dot_sum,
  output logic                                   out_last
);
  import mvm_pkg::*;

  mac_ctl_t                   ctl2_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [SUM_W-1:0]    acc_r;
  logic signed [SUM_W-1:0]    acc_nxt;
  logic                       out_valid_r;
  logic [ROW_IDX_W-1:0]       out_row_r;
  logic signed [SUM_W-1:0]    out_sum_r;
  logic                       out_last_r;

  assign acc_nxt = (ctl2_r.first ? '0 : acc_r) +
                   {{(SUM_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r.valid <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      ctl2_r.valid <= ctl_in.valid;
      if (ctl2_r.valid && ctl2_r.last_col) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
    ctl2_r.first    <= ctl_in.first;
    ctl2_r.last_col <= ctl_in.last_col;
    ctl2_r.zero     <= ctl_in.zero;
    ctl2_r.last_row <= ctl_in.last_row;
    ctl2_r.row      <= ctl_in.row;
    prod_r          <= ctl_in.zero ? '0 : PROD_W'(weight * elem);
    if (ctl2_r.valid) begin
      acc_r <= acc_nxt;
      if (ctl2_r.last_col) begin
        out_row_r  <= ctl2_r.row;
        out_sum_r  <= acc_nxt;
        out_last_r <= ctl2_r.last_row;
      end
    end
  end

  assign busy          = ctl2_r.valid || out_valid_r;
  assign out_valid     = out_valid_r;
  assign out_row_index = out_row_r;
  assign out_dot_sum   = out_sum_r;
  assign out_last      = out_last_r;

endmodule

// File: hdl/matrix_vector_multiply_unit.sv
// Load transactions (weight or element) stream back to back while no run is in progress.
// A run transaction holds the input stalled while one shared multiply-accumulate
// walks every row; the next row starts once the previous result is taken. Reset
// sets both size registers to 64 and clears control; weight and element storage
// is undefined until loaded.
module matrix_vector_multiply_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [mvm_pkg::OPCODE_W-1:0]           in_opcode,
  input  logic [mvm_pkg::SEL_W-1:0]              in_row_sel,
  input  logic [mvm_pkg::SEL_W-1:0]              in_col_sel,
  input  logic signed [mvm_pkg::VALUE_W-1:0]     in_value,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [mvm_pkg::ROW_IDX_W-1:0]          out_row_index,
  output logic signed [mvm_pkg::SUM_W-1:0]       out_dot_sum,
  output logic                                   out_last,
  input  logic                                   cfg_wr_en,
  input  logic [mvm_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [mvm_pkg::CFG_W-1:0]              cfg_wdata
);
  import mvm_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_WAIT  = 3'b010,
    ST_ISSUE = 3'b100
  } state_t;

  state_t              state_r, state_nxt;
  logic [CFG_W-1:0]    rows_in_use_r;
  logic [CFG_W-1:0]    cols_in_use_r;
  logic [ROW_CW-1:0]   nrows_r, nrows_nxt;
  logic [COL_CW-1:0]   ncols_r, ncols_nxt;
  logic [ROW_CW-1:0]   row_r, row_nxt;
  logic [COL_CW-1:0]   col_r, col_nxt;
  logic [WA_W-1:0]     base_r, base_nxt;
  mac_ctl_t            ctl1_r, ctl1_nxt;

  logic                in_fire;
  opcode_t             opcode;
  logic                w_we, v_we;
  logic [WA_W-1:0]     w_waddr;
  logic [WA_W-1:0]     w_raddr;
  logic [VALUE_W-1:0]  w_rdata, v_rdata;
  logic                last_col, last_row;
  logic                mac_busy;

  assign in_stall = (state_r != ST_IDLE);
  assign in_fire  = in_valid && (state_r == ST_IDLE);
  assign opcode   = opcode_t'(in_opcode);

  assign w_we    = in_fire && (opcode == OP_LOAD_WEIGHT) &&
                   (int'(in_row_sel) < MAX_ROWS) && (int'(in_col_sel) < MAX_COLS);
  assign v_we    = in_fire && (opcode == OP_LOAD_ELEM) && (int'(in_col_sel) < MAX_COLS);
  assign w_waddr = WA_W'(int'(in_row_sel) * MAX_COLS + int'(in_col_sel));
  assign w_raddr = base_r + WA_W'(col_r);

  mvm_ram #(.WIDTH(VALUE_W), .DEPTH(WDEPTH)) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (in_value),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  mvm_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_COLS)) u_vector_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (VA_W'(in_col_sel)),
    .wdata (in_value),
    .raddr (col_r[VA_W-1:0]),
    .rdata (v_rdata)
  );

  assign last_col = (ncols_r == '0) || (col_r + COL_CW'(1) == ncols_r);
  assign last_row = (row_r + ROW_CW'(1) == nrows_r);

  always_comb begin
    state_nxt = state_r;
    nrows_nxt = nrows_r;
    ncols_nxt = ncols_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    base_nxt  = base_r;
    ctl1_nxt  = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && (opcode == OP_RUN)) begin
          nrows_nxt = (int'(rows_in_use_r) > MAX_ROWS) ? ROW_CW'(MAX_ROWS)
                                                       : ROW_CW'(rows_in_use_r);
          ncols_nxt = (int'(cols_in_use_r) > MAX_COLS) ? COL_CW'(MAX_COLS)
                                                       : COL_CW'(cols_in_use_r);
          row_nxt   = '0;
          col_nxt   = '0;
          base_nxt  = '0;
          if (rows_in_use_r != '0) begin
            state_nxt = ST_WAIT;
          end
        end
      end
      ST_WAIT: begin
        if (!ctl1_r.valid && !mac_busy) begin
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        ctl1_nxt.valid    = 1'b1;
        ctl1_nxt.first    = (col_r == '0);
        ctl1_nxt.last_col = last_col;
        ctl1_nxt.zero     = (ncols_r == '0);
        ctl1_nxt.last_row = last_row;
        ctl1_nxt.row      = ROW_IDX_W'(row_r);
        if (last_col) begin
          col_nxt = '0;
          if (last_row) begin
            state_nxt = ST_IDLE;
          end else begin
            row_nxt   = row_r + ROW_CW'(1);
            base_nxt  = base_r + WA_W'(MAX_COLS);
            state_nxt = ST_WAIT;
          end
        end else begin
          col_nxt = col_r + COL_CW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      rows_in_use_r <= CFG_W'(64);
      cols_in_use_r <= CFG_W'(64);
      ctl1_r.valid  <= 1'b0;
      nrows_r       <= '0;
      ncols_r       <= '0;
      row_r         <= '0;
      col_r         <= '0;
      base_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      ctl1_r.valid <= ctl1_nxt.valid;
      nrows_r      <= nrows_nxt;
      ncols_r      <= ncols_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      base_r       <= base_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_ROWS_IN_USE: rows_in_use_r <= cfg_wdata;
          REG_COLS_IN_USE: cols_in_use_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
    ctl1_r.first    <= ctl1_nxt.first;
    ctl1_r.last_col <= ctl1_nxt.last_col;
    ctl1_r.zero     <= ctl1_nxt.zero;
    ctl1_r.last_row <= ctl1_nxt.last_row;
    ctl1_r.row      <= ctl1_nxt.row;
  end

  mvm_mac u_mac (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl_in        (ctl1_r),
    .weight        (signed'(w_rdata)),
    .elem          (signed'(v_rdata)),
    .busy          (mac_busy),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row_index (out_row_index),
    .out_dot_sum   (out_dot_sum),
    .out_last      (out_last)
  );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import mvm_pkg::*;

  localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 2 * MAX_COLS + 16;
  localparam int ITEMS_PER_PHASE = 110;

  typedef struct packed {
    logic [ROW_IDX_W-1:0]    row;
    logic signed [SUM_W-1:0] sum;
    logic                    last;
  } row_sum_t;

  typedef struct packed {
    logic                      is_cfg;
    logic [CFG_IDX_W-1:0]      reg_idx;
    logic [CFG_W-1:0]          reg_val;
    logic [OPCODE_W-1:0]       op;
    logic [SEL_W-1:0]          row;
    logic [SEL_W-1:0]          col;
    logic signed [VALUE_W-1:0] val;
    logic                      typed;
    logic [CFG_W-1:0]          typed_rows;
    logic signed [SUM_W-1:0]   typed_sum;
  } dir_step_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_stall;
  logic [OPCODE_W-1:0]       in_opcode = '0;
  logic [SEL_W-1:0]          in_row_sel = '0;
  logic [SEL_W-1:0]          in_col_sel = '0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [ROW_IDX_W-1:0]      out_row_index;
  logic signed [SUM_W-1:0]   out_dot_sum;
  logic                      out_last;
  logic                      cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]          cfg_wdata = '0;

  logic signed [VALUE_W-1:0] weight_mem [WDEPTH];
  logic signed [VALUE_W-1:0] elem_mem [MAX_COLS];
  bit                        weight_set [WDEPTH];
  bit                        elem_set [MAX_COLS];
  logic [CFG_W-1:0]          rows_reg = 7'd64;
  logic [CFG_W-1:0]          cols_reg = 7'd64;

  row_sum_t  expected_rows[$];
  dir_step_t dir_steps[$];
  int        errors = 0;
  int        src_idle_pct = 17;
  int        sink_idle_pct = 56;
  int        item_count = 0;

  matrix_vector_multiply_unit dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_row_sel    (in_row_sel),
    .in_col_sel    (in_col_sel),
    .in_value      (in_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_row_index (out_row_index),
    .out_dot_sum   (out_dot_sum),
    .out_last      (out_last),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #2 clk = ~clk;

  task automatic report_mismatch(string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_row(logic [ROW_IDX_W-1:0] row, logic signed [SUM_W-1:0] sum,
                           logic last);
    row_sum_t want;
    if (expected_rows.size() == 0) begin
      report_mismatch($sformatf("unexpected result row %0d sum %0d last %0d", row, sum, last));
    end else begin
      want = expected_rows.pop_front();
      if (row !== want.row)
        report_mismatch($sformatf("row_index %0d, want %0d", row, want.row));
      if (sum !== want.sum)
        report_mismatch($sformatf("row %0d dot_sum %0d, want %0d", want.row, sum, want.sum));
      if (last !== want.last)
        report_mismatch($sformatf("row %0d last %0d, want %0d", want.row, last, want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_row(out_row_index, out_dot_sum, out_last);
    out_stall <= ($urandom_range(99) < sink_idle_pct);
  end

  function automatic int active_rows();
    return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
  endfunction

  function automatic int active_cols();
    return (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
  endfunction

  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  task automatic predict_row_sums();
    int nr;
    int nc;
    longint acc;
    row_sum_t res;
    nr = active_rows();
    nc = active_cols();
    for (int r = 0; r < nr; r++) begin
      acc = 0;
      for (int c = 0; c < nc; c++)
        acc += longint'(weight_mem[r * MAX_COLS + c]) * longint'(elem_mem[c]);
      res.row = ROW_IDX_W'(r);
      res.sum = acc[SUM_W-1:0];
      res.last = (r == nr - 1);
      expected_rows.push_back(res);
    end
  endtask

  task automatic apply_item(logic [OPCODE_W-1:0] op, logic [SEL_W-1:0] row,
                            logic [SEL_W-1:0] col, logic signed [VALUE_W-1:0] val);
    case (op)
      OP_LOAD_WEIGHT: begin
        weight_mem[int'(row) * MAX_COLS + int'(col)] = val;
        weight_set[int'(row) * MAX_COLS + int'(col)] = 1'b1;
      end
      OP_LOAD_ELEM: begin
        elem_mem[col] = val;
        elem_set[col] = 1'b1;
      end
      OP_RUN: predict_row_sums();
      default: ;
    endcase
  endtask

  task automatic send_item(logic [OPCODE_W-1:0] op, logic [SEL_W-1:0] row,
                           logic [SEL_W-1:0] col, logic signed [VALUE_W-1:0] val);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_row_sel <= row;
    in_col_sel <= col;
    in_value   <= val;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic issue_item(logic [OPCODE_W-1:0] op, logic [SEL_W-1:0] row,
                            logic [SEL_W-1:0] col, logic signed [VALUE_W-1:0] val);
    send_item(op, row, col, val);
    apply_item(op, row, col, val);
    item_count++;
  endtask

  task automatic drain_results(bit settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_rows.size() != 0) @(posedge clk);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    if (idx == REG_ROWS_IN_USE) rows_reg = val;
    else cols_reg = val;
  endtask

  // load whatever the next run would read that has never been written
  task automatic fill_active();
    int nr;
    int nc;
    nr = active_rows();
    nc = active_cols();
    for (int r = 0; r < nr; r++)
      for (int c = 0; c < nc; c++)
        if (!weight_set[r * MAX_COLS + c])
          issue_item(OP_LOAD_WEIGHT, SEL_W'(r), SEL_W'(c), rand_value());
    for (int c = 0; c < nc; c++)
      if (!elem_set[c])
        issue_item(OP_LOAD_ELEM, SEL_W'($urandom), SEL_W'(c), rand_value());
  endtask

  task automatic run_segment(int rows, int cols);
    int nruns;
    int nloads;
    logic [SEL_W-1:0] r;
    logic [SEL_W-1:0] c;
    drain_results(1);
    write_cfg(REG_ROWS_IN_USE, CFG_W'(rows));
    write_cfg(REG_COLS_IN_USE, CFG_W'(cols));
    nruns = $urandom_range(1, 4);
    repeat (nruns) begin
      fill_active();
      nloads = $urandom_range(0, 6);
      repeat (nloads) begin
        r = SEL_W'($urandom);
        c = SEL_W'($urandom);
        if ($urandom_range(1) && active_rows() > 0 && active_cols() > 0) begin
          r = SEL_W'($urandom_range(active_rows() - 1));
          c = SEL_W'($urandom_range(active_cols() - 1));
        end
        if ($urandom_range(2) == 0) issue_item(OP_LOAD_ELEM, r, c, rand_value());
        else issue_item(OP_LOAD_WEIGHT, r, c, rand_value());
      end
      if ($urandom_range(5) == 0)
        issue_item(OP_UNUSED, SEL_W'($urandom), SEL_W'($urandom), VALUE_W'($urandom));
      issue_item(OP_RUN, SEL_W'($urandom), SEL_W'($urandom), VALUE_W'($urandom));
      if ($urandom_range(4) == 0) drain_results(0);
    end
  endtask

  task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, int val);
    dir_step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.reg_idx = idx;
    s.reg_val = CFG_W'(val);
    dir_steps.push_back(s);
  endtask

  task automatic add_item(logic [OPCODE_W-1:0] op, int row, int col, logic [VALUE_W-1:0] val);
    dir_step_t s;
    s = '0;
    s.op = op;
    s.row = SEL_W'(row);
    s.col = SEL_W'(col);
    s.val = val;
    dir_steps.push_back(s);
  endtask

  task automatic add_typed_run(int nrows, longint sum);
    dir_step_t s;
    s = '0;
    s.op = OP_RUN;
    s.row = 6'h3F;
    s.col = 6'h15;
    s.val = 16'h5A5A;
    s.typed = 1'b1;
    s.typed_rows = CFG_W'(nrows);
    s.typed_sum = sum[SUM_W-1:0];
    dir_steps.push_back(s);
  endtask

  initial begin
    dir_step_t s;
    row_sum_t res;
    int rows;
    int cols;

    add_cfg(REG_ROWS_IN_USE, 1);
    add_cfg(REG_COLS_IN_USE, 1);
    add_item(OP_LOAD_WEIGHT, 0, 0, 16'h8000);
    add_item(OP_LOAD_ELEM, 63, 0, 16'h8000);
    add_typed_run(1, 64'sd1073741824);
    add_item(OP_LOAD_WEIGHT, 0, 0, 16'h7FFF);
    add_typed_run(1, -64'sd1073709056);
    add_item(OP_LOAD_ELEM, 0, 0, 16'h7FFF);
    add_typed_run(1, 64'sd1073676289);
    add_item(OP_UNUSED, 42, 21, 16'hFFFF);
    add_cfg(REG_ROWS_IN_USE, 0);
    add_typed_run(0, 0);
    add_cfg(REG_ROWS_IN_USE, 2);
    add_cfg(REG_COLS_IN_USE, 0);
    add_typed_run(2, 0);
    add_cfg(REG_ROWS_IN_USE, 3);
    add_cfg(REG_COLS_IN_USE, 2);
    add_item(OP_LOAD_WEIGHT, 0, 1, 16'h1234);
    add_item(OP_LOAD_WEIGHT, 1, 0, 16'h8001);
    add_item(OP_LOAD_WEIGHT, 1, 1, 16'h7FFF);
    add_item(OP_LOAD_WEIGHT, 2, 0, 16'hFFFF);
    add_item(OP_LOAD_WEIGHT, 2, 1, 16'h0001);
    add_item(OP_LOAD_ELEM, 21, 1, 16'h0FFF);
    add_item(OP_LOAD_WEIGHT, 63, 63, 16'h7FFF);
    add_item(OP_LOAD_ELEM, 0, 63, 16'h8000);
    add_item(OP_RUN, 12, 34, 16'hC3C3);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_steps[i]) begin
      s = dir_steps[i];
      if (s.is_cfg) begin
        drain_results(1);
        write_cfg(s.reg_idx, s.reg_val);
      end else begin
        send_item(s.op, s.row, s.col, s.val);
        if (s.typed) begin
          for (int r = 0; r < int'(s.typed_rows); r++) begin
            res.row = ROW_IDX_W'(r);
            res.sum = s.typed_sum;
            res.last = (r == int'(s.typed_rows) - 1);
            expected_rows.push_back(res);
          end
        end else begin
          apply_item(s.op, s.row, s.col, s.val);
        end
      end
    end

    for (int p = 0; p < 3; p++) begin
      src_idle_pct = (p == 0) ? 17 : (p == 1) ? 56 : 0;
      sink_idle_pct = (p == 0) ? 56 : (p == 1) ? 17 : 0;
      item_count = 0;
      // register values above the maximum
      if (p == 2) begin
        run_segment(127, 2);
        run_segment(2, 127);
      end
      while (item_count < ITEMS_PER_PHASE) begin
        case ($urandom_range(9))
          0: begin
            rows = 0;
            cols = $urandom_range(127);
          end
          1: begin
            rows = $urandom_range(1, 8);
            cols = 0;
          end
          2, 3: begin
            rows = $urandom_range(1, 3);
            cols = $urandom_range(33, 127);
          end
          4: begin
            rows = $urandom_range(33, 127);
            cols = $urandom_range(1, 3);
          end
          default: begin
            rows = $urandom_range(1, 8);
            cols = $urandom_range(1, 8);
          end
        endcase
        run_segment(rows, cols);
      end
    end

    drain_results(1);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
